@@ rtl/sqtoc_pkg.sv @@
// Package: shared types, constants and register codes for the subcode frame detector.
`default_nettype none

package sqtoc_pkg;

  // Frame geometry
  localparam int unsigned FrameBytesDef = 12;
  localparam int unsigned BitIdxW       = 3;
  localparam int unsigned ByteW         = 8;

  typedef logic [ByteW-1:0] byte_t;

  // Hysteresis counter and tick counter
  localparam int unsigned HystW = 6;
  localparam int unsigned TickW = 16;

  typedef logic [HystW-1:0] hyst_t;
  typedef logic [TickW-1:0] tick_t;

  localparam hyst_t HystMax = '1;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TRIGGER_LEVEL = 2'd0,
    CFG_RELOAD_LEVEL  = 2'd1,
    CFG_TIMEOUT_TICKS = 2'd2
  } cfg_idx_e;

  localparam hyst_t TriggerRst = 6'd17;
  localparam hyst_t ReloadRst  = 6'd11;
  localparam tick_t TimeoutRst = 16'd1000;

  // Frame byte positions read by the rule
  localparam int unsigned PosB0 = 0;
  localparam int unsigned PosB1 = 1;
  localparam int unsigned PosB2 = 2;
  localparam int unsigned PosB3 = 3;
  localparam int unsigned PosB6 = 6;

  // Control byte bits for a data sector
  localparam int unsigned CtlDataBit  = 6;
  localparam int unsigned CtlCopyBit  = 4;
  localparam int unsigned CtlTopBit   = 7;

  // Byte codes used by the rule
  localparam byte_t CodeCtlAudio = 8'h01;
  localparam byte_t CodePtA0     = 8'hA0;
  localparam byte_t CodePtA1     = 8'hA1;
  localparam byte_t CodePtA2     = 8'hA2;
  localparam byte_t CodePt01     = 8'h01;
  localparam byte_t CodeMinHi    = 8'h98;
  localparam byte_t CodeMinLo    = 8'h02;

  // Bytes of a completed frame that the rule looks at
  typedef struct packed {
    byte_t b0;
    byte_t b1;
    byte_t b2;
    byte_t b3;
    byte_t b6;
  } frame_view_t;

  // Outcome of the rule for one tick
  typedef struct packed {
    logic  inject;
    hyst_t level;
  } judge_res_t;

endpackage

`default_nettype wire

@@ rtl/sqtoc_if.sv @@
// Interfaces: valid/ready channels for line samples and detector results.
`default_nettype none

interface sqtoc_sample_if;
  import sqtoc_pkg::*;

  logic valid;
  logic ready;
  logic clock_level;
  logic data_level;

  modport source (output valid, output clock_level, output data_level, input ready);
  modport sink   (input valid, input clock_level, input data_level, output ready);
endinterface

interface sqtoc_result_if;
  import sqtoc_pkg::*;

  logic  valid;
  logic  ready;
  logic  frame_done;
  logic  inject_start;
  hyst_t hysteresis_level;

  modport source (output valid, output frame_done, output inject_start,
                  output hysteresis_level, input ready);
  modport sink   (input valid, input frame_done, input inject_start,
                  input hysteresis_level, output ready);
endinterface

`default_nettype wire

@@ rtl/sqtoc_judge.sv @@
// Frame rule and hysteresis counter with trigger and reload.
`default_nettype none

module sqtoc_judge (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      en_i,
  input  sqtoc_pkg::frame_view_t   frame_i,
  input  sqtoc_pkg::hyst_t         trigger_i,
  input  sqtoc_pkg::hyst_t         reload_i,
  output sqtoc_pkg::judge_res_t    res_o
);
  import sqtoc_pkg::*;

  hyst_t hyst_q, hyst_d;
  hyst_t stepped;
  logic  data_sector;
  logic  quiet_bytes;
  logic  pointer_hit;
  logic  inc;
  logic  fire;

  // Classify the frame
  assign data_sector = frame_i.b0[CtlDataBit] & ~frame_i.b0[CtlCopyBit] &
                       ~frame_i.b0[CtlTopBit];
  assign quiet_bytes = (frame_i.b1 == '0) && (frame_i.b6 == '0);
  assign pointer_hit = (frame_i.b2 == CodePtA0) || (frame_i.b2 == CodePtA1) ||
                       (frame_i.b2 == CodePtA2) ||
                       ((frame_i.b2 == CodePt01) &&
                        ((frame_i.b3 >= CodeMinHi) || (frame_i.b3 <= CodeMinLo)));
  assign inc = (data_sector && quiet_bytes && pointer_hit) ||
               ((hyst_q != '0) && ((frame_i.b0 == CodeCtlAudio) || data_sector) &&
                quiet_bytes);

  // Step the counter, saturating at both ends
  always_comb begin
    if (inc) begin
      stepped = (hyst_q != HystMax) ? hyst_q + hyst_t'(1) : hyst_q;
    end else begin
      stepped = (hyst_q != '0) ? hyst_q - hyst_t'(1) : hyst_q;
    end
  end

  assign fire = (stepped >= trigger_i);

  // Apply only on a completed frame
  always_comb begin
    hyst_d       = hyst_q;
    res_o.inject = 1'b0;
    if (en_i) begin
      hyst_d       = fire ? reload_i : stepped;
      res_o.inject = fire;
    end
    res_o.level  = hyst_d;
  end

  // Hold the counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hyst_q <= '0;
    end else begin
      hyst_q <= hyst_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/subq_frame_toc_hysteresis_detector.sv @@
// Top level: serial subcode frame assembly, timeout and hysteresis trigger.
//
//   channel   | dir | payload                                        | transfer
//   ----------+-----+------------------------------------------------+----------------
//   sample_i  | in  | clock_level, data_level                        | valid & ready
//   result_o  | out | frame_done, inject_start, hysteresis_level     | valid & ready
//   cfg       | in  | cfg_idx_i, cfg_data_i                          | cfg_we_i
//
// One sample per cycle while result_o does not stall; each sample yields its result in the cycle after its transfer.
// All state updates and the frame rule run in one pass into the result register.
// sample_i.ready is high whenever the result register is empty or being taken,
// so a stall on result_o holds at most one pending result.
// Reset clears all control state and loads the register defaults; the frame
// store holds no reset and every entry read by the rule is written first.
`default_nettype none

module subq_frame_toc_hysteresis_detector #(
  parameter int unsigned FRAME_BYTES = sqtoc_pkg::FrameBytesDef
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  sqtoc_sample_if.sink                   sample_i,
  sqtoc_result_if.source                 result_o,
  input  wire                            cfg_we_i,
  input  wire [sqtoc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire [sqtoc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import sqtoc_pkg::*;

  localparam int unsigned ByteIdxW = $clog2(FRAME_BYTES);
  localparam logic [ByteIdxW:0] FrameLen = (ByteIdxW+1)'(FRAME_BYTES);

  // Configuration registers
  hyst_t trigger_q, reload_q;
  tick_t timeout_q;

  // Frame assembly state
  logic                 last_clk_q, last_clk_d;
  tick_t                hi_cnt_q, hi_cnt_d;
  logic [BitIdxW-1:0]   bit_idx_q, bit_idx_d;
  byte_t                shift_q, shift_d;
  logic [ByteIdxW-1:0]  byte_idx_q, byte_idx_d;
  byte_t                store_q [FRAME_BYTES];

  // Result register
  logic  out_valid_q;
  logic  done_q;
  logic  inject_q;
  hyst_t level_q;

  logic          xfer_in;
  logic          rise;
  logic          hold_hi;
  byte_t         byte_new;
  logic          byte_end;
  logic [ByteIdxW:0] byte_nxt;
  logic          frame_end;
  tick_t         hi_cnt_inc;
  logic          timeout_hit;
  frame_view_t   frame_view;
  judge_res_t    judge_res;

  // Pick a frame byte; the last byte of the frame comes from the shifter
  function automatic byte_t pick_byte(input int unsigned pos);
    byte_t res;
    if (pos == FRAME_BYTES - 1) begin
      res = byte_new;
    end else begin
      res = store_q[ByteIdxW'(pos)];
    end
    return res;
  endfunction

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trigger_q <= TriggerRst;
      reload_q  <= ReloadRst;
      timeout_q <= TimeoutRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TRIGGER_LEVEL: trigger_q <= cfg_data_i[HystW-1:0];
        CFG_RELOAD_LEVEL:  reload_q  <= cfg_data_i[HystW-1:0];
        CFG_TIMEOUT_TICKS: timeout_q <= cfg_data_i[TickW-1:0];
        default: ;
      endcase
    end
  end

  // Input handshake
  assign sample_i.ready = !out_valid_q || result_o.ready;
  assign xfer_in        = sample_i.valid && sample_i.ready;

  // Edge, byte and frame detection
  assign rise      = sample_i.clock_level && !last_clk_q;
  assign hold_hi   = sample_i.clock_level && last_clk_q;
  assign byte_new  = shift_q | (byte_t'(sample_i.data_level) << bit_idx_q);
  assign byte_end  = rise && (bit_idx_q == '1);
  assign byte_nxt  = {1'b0, byte_idx_q} + (ByteIdxW+1)'(1);
  assign frame_end = byte_end && (byte_nxt >= FrameLen);

  // Saturating high-time counter and timeout
  assign hi_cnt_inc  = (hi_cnt_q != '1) ? hi_cnt_q + tick_t'(1) : hi_cnt_q;
  assign timeout_hit = (hi_cnt_inc > timeout_q);

  // Next frame-assembly state
  always_comb begin
    last_clk_d = last_clk_q;
    hi_cnt_d   = hi_cnt_q;
    bit_idx_d  = bit_idx_q;
    shift_d    = shift_q;
    byte_idx_d = byte_idx_q;
    if (xfer_in) begin
      last_clk_d = sample_i.clock_level;
      if (rise) begin
        hi_cnt_d  = '0;
        bit_idx_d = bit_idx_q + BitIdxW'(1);
        shift_d   = byte_end ? '0 : byte_new;
        if (byte_end) begin
          byte_idx_d = frame_end ? '0 : byte_nxt[ByteIdxW-1:0];
        end
      end else if (hold_hi) begin
        hi_cnt_d = hi_cnt_inc;
        if (timeout_hit) begin
          hi_cnt_d   = '0;
          bit_idx_d  = '0;
          shift_d    = '0;
          byte_idx_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_clk_q <= 1'b1;
      hi_cnt_q   <= '0;
      bit_idx_q  <= '0;
      shift_q    <= '0;
      byte_idx_q <= '0;
    end else begin
      last_clk_q <= last_clk_d;
      hi_cnt_q   <= hi_cnt_d;
      bit_idx_q  <= bit_idx_d;
      shift_q    <= shift_d;
      byte_idx_q <= byte_idx_d;
    end
  end

  // Store each finished byte at its frame position
  always_ff @(posedge clk_i) begin
    if (xfer_in && byte_end) begin
      store_q[byte_idx_q] <= byte_new;
    end
  end

  // Frame rule
  always_comb begin
    frame_view.b0 = pick_byte(PosB0);
    frame_view.b1 = pick_byte(PosB1);
    frame_view.b2 = pick_byte(PosB2);
    frame_view.b3 = pick_byte(PosB3);
    frame_view.b6 = pick_byte(PosB6);
  end

  sqtoc_judge u_judge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (xfer_in && frame_end),
    .frame_i   (frame_view),
    .trigger_i (trigger_q),
    .reload_i  (reload_q),
    .res_o     (judge_res)
  );

  // Result register: load on an input transfer, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (xfer_in) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer_in) begin
      done_q   <= frame_end;
      inject_q <= judge_res.inject;
      level_q  <= judge_res.level;
    end
  end

  assign result_o.valid            = out_valid_q;
  assign result_o.frame_done       = done_q;
  assign result_o.inject_start     = inject_q;
  assign result_o.hysteresis_level = level_q;

  // A trigger only comes with a completed frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && inject_q) |-> done_q)
    else $error("inject_start without frame_done");

  // An empty result register never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> sample_i.ready)
    else $error("input stalled with empty result register");

  // Every input transfer leaves a result pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer_in |=> out_valid_q)
    else $error("input transfer produced no result");

  // Byte position stays inside the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, byte_idx_q} < FrameLen))
    else $error("byte position beyond frame length");

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Testbench: subcode frame detector driven with serial line samples and checked per tick.
`default_nettype none

module testbench;
  import sqtoc_pkg::*;

  localparam int unsigned FrameLen    = FrameBytesDef;
  localparam int unsigned LimitCycles = 500_000;

  typedef struct packed {
    logic clock_level;
    logic data_level;
  } line_sample_t;

  typedef struct packed {
    logic  frame_done;
    logic  inject_start;
    hyst_t level;
  } tick_outcome_t;

  typedef enum int {
    PACE_SEND_SLOW,
    PACE_RECV_SLOW,
    PACE_FULL
  } pace_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  sqtoc_sample_if sample_ch ();
  sqtoc_result_if result_ch ();

  subq_frame_toc_hysteresis_detector u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (sample_ch),
    .result_o   (result_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Predictor copy of the registers and the frame state
  hyst_t              trig_cfg;
  hyst_t              reload_cfg;
  tick_t              timeout_cfg;
  logic               prev_clk;
  tick_t              high_ticks;
  logic [BitIdxW-1:0] bit_pos;
  byte_t              shift_acc;
  logic [3:0]         byte_pos;
  byte_t              frame_buf [FrameLen];
  hyst_t              hyst;

  line_sample_t  line_samples [$];
  tick_outcome_t outcome_q [$];
  byte_t         stim_frame [FrameLen];
  int unsigned   send_idle;
  int unsigned   recv_idle;
  int unsigned   error_count;

  // Advance the frame state by one line sample and return what the block owes for it
  function automatic tick_outcome_t predict_tick(logic clk_lvl, logic dat_lvl);
    tick_outcome_t res;
    byte_t         b0, b1, b2, b3, b6;
    logic          ds, clean, ptr_hit, raise;
    res = '0;
    if (clk_lvl && !prev_clk) begin
      high_ticks = '0;
      if (dat_lvl) shift_acc[bit_pos] = 1'b1;
      bit_pos = bit_pos + 1'b1;
      if (bit_pos == '0) begin
        frame_buf[byte_pos] = shift_acc;
        shift_acc = '0;
        byte_pos = byte_pos + 1'b1;
        if (byte_pos >= FrameLen) begin
          byte_pos = '0;
          res.frame_done = 1'b1;
          b0 = frame_buf[PosB0];
          b1 = frame_buf[PosB1];
          b2 = frame_buf[PosB2];
          b3 = frame_buf[PosB3];
          b6 = frame_buf[PosB6];
          ds = b0[CtlDataBit] && !b0[CtlCopyBit] && !b0[CtlTopBit];
          clean = (b1 == '0) && (b6 == '0);
          ptr_hit = b2 == CodePtA0 || b2 == CodePtA1 || b2 == CodePtA2 ||
                    (b2 == CodePt01 && (b3 >= CodeMinHi || b3 <= CodeMinLo));
          raise = (ds && clean && ptr_hit) ||
                  (hyst != '0 && (b0 == CodeCtlAudio || ds) && clean);
          // Saturate up, floor at zero going down
          if (raise) begin
            if (hyst != HystMax) hyst = hyst + 1'b1;
          end else if (hyst != '0) begin
            hyst = hyst - 1'b1;
          end
          if (hyst >= trig_cfg) begin
            hyst = reload_cfg;
            res.inject_start = 1'b1;
          end
        end
      end
    end else if (clk_lvl) begin
      // Clock held high: count toward the timeout, then drop the frame position
      if (high_ticks != '1) high_ticks = high_ticks + 1'b1;
      if (high_ticks > timeout_cfg) begin
        high_ticks = '0;
        bit_pos    = '0;
        shift_acc  = '0;
        byte_pos   = '0;
      end
    end
    prev_clk  = clk_lvl;
    res.level = hyst;
    return res;
  endfunction

  // Drive line samples; predict each one at its transfer
  always @(posedge clk_i or negedge rst_ni) begin
    line_sample_t nxt;
    logic         hold;
    if (!rst_ni) begin
      sample_ch.valid       <= 1'b0;
      sample_ch.clock_level <= 1'b0;
      sample_ch.data_level  <= 1'b0;
    end else begin
      hold = sample_ch.valid && !sample_ch.ready;
      if (sample_ch.valid && sample_ch.ready)
        outcome_q.push_back(predict_tick(sample_ch.clock_level, sample_ch.data_level));
      if (!hold) begin
        if (line_samples.size() != 0 && $urandom_range(99) >= send_idle) begin
          nxt = line_samples.pop_front();
          sample_ch.valid       <= 1'b1;
          sample_ch.clock_level <= nxt.clock_level;
          sample_ch.data_level  <= nxt.data_level;
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Take results and compare them with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    tick_outcome_t want;
    if (!rst_ni) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (outcome_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result done=%0b inject=%0b level=%0d", $time,
                   result_ch.frame_done, result_ch.inject_start, result_ch.hysteresis_level);
        end else begin
          want = outcome_q.pop_front();
          if (result_ch.frame_done !== want.frame_done) begin
            error_count++;
            $display("%0t: frame_done expected %0b actual %0b", $time,
                     want.frame_done, result_ch.frame_done);
          end
          if (result_ch.inject_start !== want.inject_start) begin
            error_count++;
            $display("%0t: inject_start expected %0b actual %0b", $time,
                     want.inject_start, result_ch.inject_start);
          end
          if (result_ch.hysteresis_level !== want.level) begin
            error_count++;
            $display("%0t: hysteresis_level expected %0d actual %0d", $time,
                     want.level, result_ch.hysteresis_level);
          end
        end
      end
      result_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic set_pace(pace_e p);
    case (p)
      PACE_SEND_SLOW: begin
        send_idle = 37;
        recv_idle = 46;
      end
      PACE_RECV_SLOW: begin
        send_idle = 46;
        recv_idle = 37;
      end
      default: begin
        send_idle = 0;
        recv_idle = 0;
      end
    endcase
  endtask

  task automatic push_tick(logic c, logic d);
    line_samples.push_back({c, d});
  endtask

  // One serial bit: low phase, rising edge, sometimes a short high hold
  task automatic push_bit(logic b);
    repeat ($urandom_range(1, 2)) push_tick(1'b0, 1'($urandom));
    push_tick(1'b1, b);
    if ($urandom_range(3) == 0) push_tick(1'b1, 1'($urandom));
  endtask

  task automatic push_byte(byte_t b);
    for (int i = 0; i < 8; i++) push_bit(b[i]);
  endtask

  // Hold the clock high past the timeout so the next bit starts a frame
  task automatic realign();
    push_tick(1'b0, 1'($urandom));
    repeat (int'(timeout_cfg) + 2) push_tick(1'b1, 1'($urandom));
  endtask

  // Fill stim_frame: mostly frames the rule counts up, the rest near misses and junk
  task automatic make_frame();
    int unsigned pick;
    for (int i = 0; i < FrameLen; i++) stim_frame[i] = byte_t'($urandom);
    pick = $urandom_range(99);
    if (pick < 85) begin
      stim_frame[PosB0][CtlDataBit] = 1'b1;
      stim_frame[PosB0][CtlCopyBit] = 1'b0;
      stim_frame[PosB0][CtlTopBit]  = 1'b0;
      stim_frame[PosB1] = '0;
      stim_frame[PosB6] = '0;
    end
    if (pick < 55) begin
      case ($urandom_range(4))
        0: stim_frame[PosB2] = CodePtA0;
        1: stim_frame[PosB2] = CodePtA1;
        2: stim_frame[PosB2] = CodePtA2;
        default: begin
          stim_frame[PosB2] = CodePt01;
          case ($urandom_range(4))
            0: stim_frame[PosB3] = CodeMinHi;
            1: stim_frame[PosB3] = 8'hFF;
            2: stim_frame[PosB3] = CodeMinLo;
            3: stim_frame[PosB3] = 8'h00;
            default: ;
          endcase
        end
      endcase
    end else if (pick < 70) begin
      // Continuation frame: counts only while the counter is nonzero
      if ($urandom_range(1) == 0) stim_frame[PosB0] = CodeCtlAudio;
      if ($urandom_range(1) == 0) begin
        stim_frame[PosB2] = CodePt01;
        stim_frame[PosB3] = byte_t'($urandom_range(CodeMinLo + 1, CodeMinHi - 1));
      end
    end else if (pick < 85) begin
      stim_frame[PosB2] = CodePtA1;
      case ($urandom_range(3))
        0: stim_frame[PosB1] = byte_t'($urandom_range(1, 255));
        1: stim_frame[PosB6] = byte_t'($urandom_range(1, 255));
        2: stim_frame[PosB0][CtlCopyBit] = 1'b1;
        default: stim_frame[PosB0][CtlTopBit] = 1'b1;
      endcase
    end
  endtask

  // Queue whole frames; with noise, mix in junk ticks and cut-off frames
  task automatic push_frames(int unsigned n, logic noisy);
    repeat (n) begin
      make_frame();
      for (int i = 0; i < FrameLen; i++) push_byte(stim_frame[i]);
      if (noisy && $urandom_range(99) < 35) begin
        if ($urandom_range(1) == 0) begin
          repeat ($urandom_range(3, 20)) push_tick(1'($urandom), 1'($urandom));
        end else begin
          repeat ($urandom_range(1, FrameLen - 1)) push_byte(byte_t'($urandom));
          repeat ($urandom_range(0, 7)) push_bit(1'($urandom));
        end
        realign();
      end
    end
  endtask

  // Wait until no sample or result is in flight
  task automatic wait_drained();
    do @(negedge clk_i);
    while (line_samples.size() != 0 || sample_ch.valid || outcome_q.size() != 0 ||
           result_ch.valid);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_TRIGGER_LEVEL: trig_cfg    = val[HystW-1:0];
      CFG_RELOAD_LEVEL:  reload_cfg  = val[HystW-1:0];
      CFG_TIMEOUT_TICKS: timeout_cfg = val[TickW-1:0];
      default: ;
    endcase
  endtask

  task automatic run_phase(hyst_t trig, hyst_t reload, tick_t tmo, pace_e p,
                           int unsigned frames, logic noisy);
    wait_drained();
    write_reg(CFG_TRIGGER_LEVEL, CfgDataW'(trig));
    write_reg(CFG_RELOAD_LEVEL, CfgDataW'(reload));
    write_reg(CFG_TIMEOUT_TICKS, CfgDataW'(tmo));
    set_pace(p);
    if (tmo <= TimeoutRst) realign();
    push_frames(frames, noisy);
  endtask

  // Run out of time
  initial begin
    #(LimitCycles * 20);
    $display("subq_frame_toc_hysteresis_detector verification failed");
    $finish;
  end

  initial begin
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = CFG_TRIGGER_LEVEL;
    cfg_data_i            = '0;
    sample_ch.valid       = 1'b0;
    sample_ch.clock_level = 1'b0;
    sample_ch.data_level  = 1'b0;
    result_ch.ready       = 1'b0;
    error_count           = 0;
    trig_cfg              = TriggerRst;
    reload_cfg            = ReloadRst;
    timeout_cfg           = TimeoutRst;
    prev_clk              = 1'b1;
    high_ticks            = '0;
    bit_pos               = '0;
    shift_acc             = '0;
    byte_pos              = '0;
    hyst                  = '0;
    set_pace(PACE_SEND_SLOW);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: clock high out of reset, timeout boundary, edges with both data values
    write_reg(CFG_TIMEOUT_TICKS, CfgDataW'(2));
    push_tick(1'b1, 1'b1);
    push_tick(1'b1, 1'b0);
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b1);
    push_tick(1'b1, 1'b0);
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b0);
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b1);
    push_tick(1'b1, 1'b0);
    push_tick(1'b1, 1'b1);
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b0);
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b0);
    push_tick(1'b1, 1'b0);

    // Random frames across register settings, extremes included
    run_phase(6'd1, 6'd0, 16'd1, PACE_SEND_SLOW, 1, 1'b1);
    // Reload at the top so the counter saturates on the next increment
    run_phase(6'd1, 6'd63, 16'hFFFF, PACE_SEND_SLOW, 1, 1'b0);
    run_phase(6'd63, 6'd63, 16'hFFFF, PACE_RECV_SLOW, 1, 1'b0);
    // Trigger level zero fires on every frame
    run_phase(6'd0, 6'd0, 16'hFFFF, PACE_RECV_SLOW, 1, 1'b0);
    run_phase(6'd3, 6'd1, 16'd40, PACE_FULL, 0, 1'b0);

    // Stop the sender mid-frame until everything owed has come back
    make_frame();
    for (int i = 0; i < FrameLen / 2; i++) push_byte(stim_frame[i]);
    wait_drained();
    for (int i = FrameLen / 2; i < FrameLen; i++) push_byte(stim_frame[i]);
    run_phase(6'd5, 6'd2, 16'd8, PACE_FULL, 0, 1'b0);

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("subq_frame_toc_hysteresis_detector verification clean");
    end else begin
      $display("subq_frame_toc_hysteresis_detector verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
